/* hdl/assert_macros.svh */
// Assertion macros shared by the accel trend classifier RTL.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* hdl/atc_pkg.sv */
// Package for the accel trend classifier: widths, defaults, codes and types.
// No dependencies; used by the front, back and top modules.
package atc_pkg;

    // Field widths
    localparam int SAMPLE_W    = 13;
    localparam int THR_W       = 13;
    localparam int LIMIT_W     = 24;
    localparam int CORR_W      = 14;
    localparam int CLASS_W     = 2;

    // Port widths
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // Parameter defaults
    localparam int FILTER_TAPS_DEF = 10;
    localparam int BIAS_WINDOW_DEF = 50;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Register reset values
    localparam logic [THR_W-1:0]   THR_RESET   = 13'd25;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd300;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_THRESHOLD = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STILL_LIMIT     = 1'd1;

    // Speed class codes
    localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UP     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DOWN   = 2'd2;

    typedef struct packed {
        logic [THR_W-1:0]   accel_threshold;
        logic [LIMIT_W-1:0] variance_limit;
    } cfg_t;

    // Result item, speed_class in the lowest bits
    typedef struct packed {
        logic signed [CORR_W-1:0] corrected_accel;
        logic                     class_changed;
        logic [CLASS_W-1:0]       speed_class;
    } result_t;

endpackage

/* hdl/atc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module atc_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/atc_div.sv */
// Divider by a constant: reciprocal multiplication on the magnitude,
// truncating toward zero for signed dividends. Uses no package.
module atc_div #(
    parameter int DW      = 17,
    parameter int DIVISOR = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    output logic                 busy,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);

    // floor(m * RECIP / 2^SHIFT) equals floor(m / DIVISOR) for every m below 2^DW
    localparam int              LOG_D   = $clog2(DIVISOR);
    localparam int              SHIFT   = DW + LOG_D;
    localparam int              RW      = DW + 1;
    localparam int              PW      = SHIFT + DW;
    localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                          / 64'(DIVISOR);
    localparam logic [RW-1:0]   RECIP   = RW'(RECIP_L);

    logic [DW-1:0] mag_reg, mag_next;
    logic [DW-1:0] q_reg, q_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] product;

    assign product = PW'(mag_reg) * PW'(RECIP);

    // Capture the magnitude on start, multiply in the following cycle
    always_comb
    begin
        mag_next  = mag_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            mag_next  = dividend[DW-1] ? $unsigned(-dividend) : $unsigned(dividend);
            neg_next  = dividend[DW-1];
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next    = product[SHIFT +: DW];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = $signed(neg_reg ? -q_reg : q_reg);

endmodule

/* hdl/atc_queue.sv */
// Small FIFO of filtered samples between the front and back parts.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module atc_queue #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "queue count over depth")
    `ASSERT_PROP(a_count_track, clk, rst_n, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count lost a push")

endmodule

/* hdl/atc_front.sv */
// Front part: takes raw samples, keeps the tap ring and produces the
// trimmed mean. Depends on atc_pkg, atc_div and assert_macros.svh.
`include "assert_macros.svh"

module atc_front #(
    parameter int FILTER_TAPS = atc_pkg::FILTER_TAPS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [atc_pkg::SAMPLE_W-1:0] s_sample,
    output logic                                f_valid,
    input  logic                                f_ready,
    output logic signed [atc_pkg::SAMPLE_W-1:0] f_value
);

    localparam int SW    = atc_pkg::SAMPLE_W;
    localparam int PW    = $clog2(FILTER_TAPS);
    localparam int SUM_W = SW + $clog2(FILTER_TAPS + 1);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_SCAN = 5'b00010,
        F_TRIM = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t                  state_reg, state_next;
    logic signed [SW-1:0]     ring_reg [FILTER_TAPS];
    logic [PW-1:0]            pos_reg, pos_next;
    logic [PW-1:0]            idx_reg, idx_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SW-1:0]     hi_reg, hi_next;
    logic signed [SW-1:0]     lo_reg, lo_next;
    logic signed [SW-1:0]     filt_reg, filt_next;
    logic signed [SW-1:0]     tap;
    logic                     div_start, div_busy, div_done;
    logic signed [SUM_W-1:0]  div_quot;
    logic signed [SUM_W-1:0]  trimmed_sum;
    logic                     accept;

    assign s_ready     = (state_reg == F_IDLE);
    assign accept      = s_valid && s_ready;
    assign f_valid     = (state_reg == F_PUSH);
    assign f_value     = filt_reg;
    assign tap         = ring_reg[idx_reg];
    assign trimmed_sum = sum_reg - SUM_W'(hi_reg) - SUM_W'(lo_reg);

    // Sequencer: store sample, scan taps, divide, hand over
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        filt_next  = filt_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_valid)
                begin
                    pos_next   = (pos_reg == PW'(FILTER_TAPS - 1)) ? '0 : pos_reg + 1'b1;
                    idx_next   = '0;
                    state_next = F_SCAN;
                end
            end
            F_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    sum_next = SUM_W'(tap);
                    hi_next  = tap;
                    lo_next  = tap;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(tap);
                    hi_next  = (tap > hi_reg) ? tap : hi_reg;
                    lo_next  = (tap < lo_reg) ? tap : lo_reg;
                end
                if (idx_reg == PW'(FILTER_TAPS - 1))
                begin
                    state_next = F_TRIM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            F_TRIM:
            begin
                div_start  = 1'b1;
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    filt_next  = div_quot[SW-1:0];
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (f_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pos_reg   <= '0;
            for (int i = 0; i < FILTER_TAPS; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (accept)
            begin
                ring_reg[pos_reg] <= s_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        sum_reg  <= sum_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        filt_reg <= filt_next;
    end

    // Division by the number of kept taps
    atc_div #(
        .DW      (SUM_W),
        .DIVISOR (FILTER_TAPS - 2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (trimmed_sum),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    `ASSERT_PROP(a_pos_range, clk, rst_n, (PW + 1)'(pos_reg) < (PW + 1)'(FILTER_TAPS), "tap position out of range")
    `ASSERT_NEVER(a_div_overlap, clk, rst_n, div_start && div_busy, "trim divider restarted while busy")
    `ASSERT_PROP(a_done_in_div, clk, rst_n, div_done |-> (state_reg == F_DIV), "divider finished outside wait state")

endmodule

/* hdl/atc_back.sv */
// Back part: fills the bias window, calibrates bias when the window is full and
// its variance is below the limit, classifies and holds the result. Depends on atc_pkg, atc_ram, atc_div.
`include "assert_macros.svh"

module atc_back #(
    parameter int BIAS_WINDOW = atc_pkg::BIAS_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  logic signed [atc_pkg::SAMPLE_W-1:0] q_value,
    input  atc_pkg::cfg_t                       cfg,
    output logic                                m_valid,
    input  logic                                m_ready,
    output atc_pkg::result_t                    m_result
);

    localparam int SW     = atc_pkg::SAMPLE_W;
    localparam int CORR_W = atc_pkg::CORR_W;
    localparam int AW     = $clog2(BIAS_WINDOW);
    localparam int CNT_W  = $clog2(BIAS_WINDOW + 1);
    localparam int WSUM_W = SW + CNT_W;
    localparam int DIFF_W = SW + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ACC_W  = SQ_W + CNT_W;
    localparam int LIM_W  = atc_pkg::LIMIT_W + CNT_W;

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_MEAN  = 5'b00010,
        B_VAR   = 5'b00100,
        B_CHECK = 5'b01000,
        B_EMIT  = 5'b10000
    } bstate_t;

    bstate_t                         state_reg, state_next;
    logic [AW-1:0]                   wpos_reg, wpos_next;
    logic signed [WSUM_W-1:0]        wsum_reg, wsum_next;
    logic signed [SW-1:0]            bias_reg, bias_next;
    logic [atc_pkg::CLASS_W-1:0]     last_class_reg, last_class_next;
    logic signed [SW-1:0]            f_reg, f_next;
    logic signed [SW-1:0]            mean_reg, mean_next;
    logic [CNT_W-1:0]                issue_reg, issue_next;
    logic                            v1_reg, v1_next;
    logic                            v2_reg, v2_next;
    logic [SQ_W-1:0]                 sq_reg, sq_next;
    logic [ACC_W-1:0]                acc_reg, acc_next;
    logic [LIM_W-1:0]                lim_scaled_reg;
    logic                            m_valid_reg, m_valid_next;
    atc_pkg::result_t                m_result_reg, m_result_next;

    logic                            pop, wrap, ram_we;
    logic [SW-1:0]                   ram_rdata;
    logic signed [DIFF_W-1:0]        diff;
    logic signed [SQ_W-1:0]          sq_full;
    logic signed [WSUM_W-1:0]        wsum_add;
    logic                            div_start, div_busy, div_done;
    logic signed [WSUM_W-1:0]        div_quot;
    logic signed [CORR_W-1:0]        corr;
    logic signed [CORR_W:0]          corr_ext, thr_pos, thr_neg;
    logic [atc_pkg::CLASS_W-1:0]     cls;
    logic                            slot_free;

    assign q_ready   = (state_reg == B_IDLE);
    assign pop       = q_valid && q_ready;
    assign wrap      = (wpos_reg == AW'(BIAS_WINDOW - 1));
    assign ram_we    = pop;
    assign wsum_add  = wsum_reg + WSUM_W'(q_value);
    assign div_start = pop && wrap;
    assign slot_free = !m_valid_reg || m_ready;

    // Deviation from the window mean, squared
    assign diff    = $signed({ram_rdata[SW-1], ram_rdata}) - $signed({mean_reg[SW-1], mean_reg});
    assign sq_full = diff * diff;

    // Bias-corrected value and its class
    assign corr     = CORR_W'(f_reg) - CORR_W'(bias_reg);
    assign corr_ext = (CORR_W + 1)'(corr);
    assign thr_pos  = $signed({2'b00, cfg.accel_threshold});
    assign thr_neg  = -thr_pos;

    always_comb
    begin
        if (corr_ext > thr_pos)
        begin
            cls = atc_pkg::CLASS_UP;
        end
        else if (corr_ext < thr_neg)
        begin
            cls = atc_pkg::CLASS_DOWN;
        end
        else
        begin
            cls = atc_pkg::CLASS_NORMAL;
        end
    end

    // Sequencer: store into window, calibrate on fill, emit result
    always_comb
    begin
        state_next      = state_reg;
        wpos_next       = wpos_reg;
        wsum_next       = wsum_reg;
        bias_next       = bias_reg;
        last_class_next = last_class_reg;
        f_next          = f_reg;
        mean_next       = mean_reg;
        issue_next      = issue_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        sq_next         = sq_full;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_result_next   = m_result_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    f_next = q_value;
                    if (wrap)
                    begin
                        wpos_next  = '0;
                        wsum_next  = '0;
                        state_next = B_MEAN;
                    end
                    else
                    begin
                        wpos_next  = wpos_reg + 1'b1;
                        wsum_next  = wsum_add;
                        state_next = B_EMIT;
                    end
                end
            end
            B_MEAN:
            begin
                if (div_done)
                begin
                    mean_next  = div_quot[SW-1:0];
                    issue_next = '0;
                    acc_next   = '0;
                    state_next = B_VAR;
                end
            end
            B_VAR:
            begin
                if (issue_reg != CNT_W'(BIAS_WINDOW))
                begin
                    issue_next = issue_reg + 1'b1;
                    v1_next    = 1'b1;
                end
                v2_next = v1_reg;
                if (v2_reg)
                begin
                    acc_next = acc_reg + ACC_W'(sq_reg);
                end
                if (issue_reg == CNT_W'(BIAS_WINDOW) && !v1_reg && !v2_reg)
                begin
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (acc_reg < ACC_W'(lim_scaled_reg))
                begin
                    bias_next = mean_reg;
                end
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                begin
                    m_valid_next                  = 1'b1;
                    m_result_next.speed_class     = cls;
                    m_result_next.class_changed   = (cls != last_class_reg);
                    m_result_next.corrected_accel = corr;
                    last_class_next               = cls;
                    state_next                    = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            wpos_reg       <= '0;
            wsum_reg       <= '0;
            bias_reg       <= '0;
            last_class_reg <= atc_pkg::CLASS_NORMAL;
            m_valid_reg    <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            issue_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            wpos_reg       <= wpos_next;
            wsum_reg       <= wsum_next;
            bias_reg       <= bias_next;
            last_class_reg <= last_class_next;
            m_valid_reg    <= m_valid_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            issue_reg      <= issue_next;
        end
    end

    // Datapath registers; the limit product is registered before the compare
    always_ff @(posedge clk)
    begin
        f_reg          <= f_next;
        mean_reg       <= mean_next;
        sq_reg         <= sq_next;
        acc_reg        <= acc_next;
        m_result_reg   <= m_result_next;
        lim_scaled_reg <= LIM_W'(cfg.variance_limit) * LIM_W'(BIAS_WINDOW);
    end

    atc_ram #(
        .WIDTH (SW),
        .DEPTH (BIAS_WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (q_value),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Window mean, shared for every fill
    atc_div #(
        .DW      (WSUM_W),
        .DIVISOR (BIAS_WINDOW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (wsum_add),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    `ASSERT_PROP(a_wpos_range, clk, rst_n, CNT_W'(wpos_reg) < CNT_W'(BIAS_WINDOW), "window position out of range")
    `ASSERT_PROP(a_check_drained, clk, rst_n, (state_reg == B_CHECK) |-> (!v1_reg && !v2_reg && issue_reg == CNT_W'(BIAS_WINDOW)), "variance check before pass drained")
    `ASSERT_NEVER(a_div_overlap, clk, rst_n, div_start && div_busy, "mean divider restarted while busy")
    `ASSERT_PROP(a_bias_only_check, clk, rst_n, (bias_reg != $past(bias_reg)) |-> ($past(state_reg) == B_CHECK), "bias changed outside calibration")

endmodule

/* hdl/accel_trend_classifier_top.sv */
// Top level of the accel trend classifier: ports, configuration registers,
// front/queue/back wiring. Depends on atc_pkg, atc_front, atc_queue, atc_back.
//
// Usage:
//   s_axis carries one raw z-axis sample per transfer (tdata[12:0], signed).
//   m_axis returns exactly one result per sample, in order.
//   cfg_* writes accel_threshold (index 0) or stillness_variance_limit
//   (index 1); cfg_ready is always high. Write only while the block is idle.
// Processing:
//   Per sample the front steps through accept, one scan step per ring tap for
//   sum/min/max, trim, the reciprocal-multiply divide and the hand over; it
//   takes a new sample only when back in idle. The back stores each sample
//   and emits its result; a sample that fills the window also runs the mean
//   and the variance pass. A queue of QUEUE_DEPTH samples absorbs that pass.
// Reset and stall:
//   rst_n clears the tap ring, positions, bias, last class and registers to
//   their defaults; the window RAM needs no clearing. When m_axis_tready is
//   low the result stays held, the back stops, the queue fills and then
//   s_axis_tready drops.
module accel_trend_classifier_top #(
    parameter int FILTER_TAPS = atc_pkg::FILTER_TAPS_DEF,
    parameter int BIAS_WINDOW = atc_pkg::BIAS_WINDOW_DEF,
    parameter int QUEUE_DEPTH = atc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: [12:0] accel_z, [15:13] zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [atc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // tdata: [1:0] speed_class, [2] class_changed, [16:3] corrected_accel,
    //        [23:17] zero
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [atc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [atc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [atc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SW      = atc_pkg::SAMPLE_W;
    localparam int RES_W   = $bits(atc_pkg::result_t);
    localparam int M_PAD_W = atc_pkg::M_TDATA_W - RES_W;

    atc_pkg::cfg_t              cfg_reg, cfg_next;
    logic                       f_valid, f_ready;
    logic signed [SW-1:0]       f_value;
    logic                       q_valid, q_ready;
    logic [SW-1:0]              q_data;
    atc_pkg::result_t           result;

    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                atc_pkg::CFG_ACCEL_THRESHOLD:
                begin
                    cfg_next.accel_threshold = cfg_data[atc_pkg::THR_W-1:0];
                end
                atc_pkg::CFG_STILL_LIMIT:
                begin
                    cfg_next.variance_limit = cfg_data[atc_pkg::LIMIT_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_threshold <= atc_pkg::THR_RESET;
            cfg_reg.variance_limit  <= atc_pkg::LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    atc_front #(
        .FILTER_TAPS (FILTER_TAPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_sample (s_axis_tdata[SW-1:0]),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_value  (f_value)
    );

    atc_queue #(
        .WIDTH (SW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_value),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    atc_back #(
        .BIAS_WINDOW (BIAS_WINDOW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_value  (q_data),
        .cfg      (cfg_reg),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (result)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, result};

endmodule
